[rtl/assert_macros.svh]
// Concurrent assertion helpers; the calling scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/rtcal_pkg.sv]
package rtcal_pkg;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_TIME  = 2'd1,
    CMD_SET_DATE  = 2'd2,
    CMD_SET_ALARM = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  shown_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic        is_pm;
    logic        alarm_hit;
  } out_item_t;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [4:0]  HOUR_HALF  = 5'd12;
  localparam logic [4:0]  HOUR_DAY   = 5'd24;
  localparam logic [3:0]  MONTH_LAST = 4'd11;
  localparam logic [13:0] YEAR_LAST  = 14'd9999;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic        MODE_24H_RESET = 1'b1;

  // Fixed month lengths, February always 28; indexes past December count as 31.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:                     len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/rtcal_in_reg.sv]
module rtcal_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtcal_pkg::in_item_t in_data,
  input  logic                advance,
  output logic                item_valid,
  output rtcal_pkg::in_item_t item
);

  logic                valid_r;
  rtcal_pkg::in_item_t data_r;

  // Hold while the registered transaction cannot move on.
  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data;
    end
  end

endmodule

[rtl/rtcal_core.sv]
module rtcal_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 fire,
  input  rtcal_pkg::in_item_t  item,
  output rtcal_pkg::out_item_t result
);

  logic        mode_24h_r;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic        armed_r, armed_nxt;
  logic [4:0]  al_hour_r, al_hour_nxt;
  logic [5:0]  al_min_r, al_min_nxt;
  logic [5:0]  al_sec_r, al_sec_nxt;
  logic [4:0]  al_day_r, al_day_nxt;
  logic [3:0]  al_month_r, al_month_nxt;
  logic [13:0] al_year_r, al_year_nxt;

  logic        sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
  logic [4:0]  t_hour, t_day;
  logic [5:0]  t_min, t_sec;
  logic [3:0]  t_month;
  logic [13:0] t_year;
  logic        armed_pre, hit;
  logic [4:0]  hour_mod12;

  // Tick: ripple the carry through the counters.
  always_comb begin
    sec_wrap   = sec_r >= rtcal_pkg::SEC_LAST;
    min_wrap   = min_r >= rtcal_pkg::MIN_LAST;
    hour_wrap  = hour_r >= rtcal_pkg::HOUR_LAST;
    day_wrap   = day_r >= rtcal_pkg::month_len(month_r);
    month_wrap = month_r >= rtcal_pkg::MONTH_LAST;

    t_sec   = sec_wrap ? '0 : 6'(sec_r + 6'd1);
    t_min   = min_r;
    t_hour  = hour_r;
    t_day   = day_r;
    t_month = month_r;
    t_year  = year_r;
    if (sec_wrap) begin
      t_min = min_wrap ? '0 : 6'(min_r + 6'd1);
      if (min_wrap) begin
        t_hour = hour_wrap ? '0 : 5'(hour_r + 5'd1);
        if (hour_wrap) begin
          t_day = day_wrap ? rtcal_pkg::DAY_FIRST : 5'(day_r + 5'd1);
          if (day_wrap) begin
            t_month = month_wrap ? '0 : 4'(month_r + 4'd1);
            if (month_wrap) begin
              t_year = (year_r >= rtcal_pkg::YEAR_LAST) ? '0 : 14'(year_r + 14'd1);
            end
          end
        end
      end
    end
  end

  always_comb begin
    hour_nxt     = hour_r;
    min_nxt      = min_r;
    sec_nxt      = sec_r;
    day_nxt      = day_r;
    month_nxt    = month_r;
    year_nxt     = year_r;
    al_hour_nxt  = al_hour_r;
    al_min_nxt   = al_min_r;
    al_sec_nxt   = al_sec_r;
    al_day_nxt   = al_day_r;
    al_month_nxt = al_month_r;
    al_year_nxt  = al_year_r;
    armed_pre    = armed_r;
    unique case (item.cmd)
      rtcal_pkg::CMD_TICK: begin
        hour_nxt  = t_hour;
        min_nxt   = t_min;
        sec_nxt   = t_sec;
        day_nxt   = t_day;
        month_nxt = t_month;
        year_nxt  = t_year;
      end
      rtcal_pkg::CMD_SET_TIME: begin
        hour_nxt = item.hour;
        min_nxt  = item.minute;
        sec_nxt  = item.second;
      end
      rtcal_pkg::CMD_SET_DATE: begin
        day_nxt   = item.day;
        month_nxt = item.month;
        year_nxt  = item.year;
      end
      rtcal_pkg::CMD_SET_ALARM: begin
        al_hour_nxt  = item.hour;
        al_min_nxt   = item.minute;
        al_sec_nxt   = item.second;
        al_day_nxt   = item.day;
        al_month_nxt = item.month;
        al_year_nxt  = item.year;
        armed_pre    = 1'b1;
      end
      default: begin
      end
    endcase

    // Match against the updated time and date; a hit disarms.
    hit = armed_pre
          && hour_nxt == al_hour_nxt && min_nxt == al_min_nxt && sec_nxt == al_sec_nxt
          && day_nxt == al_day_nxt && month_nxt == al_month_nxt
          && year_nxt == al_year_nxt;
    armed_nxt = armed_pre && !hit;

    if (hour_nxt >= rtcal_pkg::HOUR_DAY) begin
      hour_mod12 = 5'(hour_nxt - rtcal_pkg::HOUR_DAY);
    end else if (hour_nxt >= rtcal_pkg::HOUR_HALF) begin
      hour_mod12 = 5'(hour_nxt - rtcal_pkg::HOUR_HALF);
    end else begin
      hour_mod12 = hour_nxt;
    end

    result.shown_hour = mode_24h_r ? hour_nxt : hour_mod12;
    result.cur_minute = min_nxt;
    result.cur_second = sec_nxt;
    result.cur_day    = day_nxt;
    result.cur_month  = month_nxt;
    result.cur_year   = year_nxt;
    result.is_pm      = hour_nxt >= rtcal_pkg::HOUR_HALF;
    result.alarm_hit  = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_24h_r <= rtcal_pkg::MODE_24H_RESET;
    end else if (cfg_we) begin
      mode_24h_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      day_r   <= rtcal_pkg::DAY_FIRST;
      month_r <= '0;
      year_r  <= '0;
      armed_r <= 1'b0;
    end else if (fire) begin
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      armed_r <= armed_nxt;
    end
  end

  // Alarm setting is only compared while armed, so it needs no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      al_hour_r  <= al_hour_nxt;
      al_min_r   <= al_min_nxt;
      al_sec_r   <= al_sec_nxt;
      al_day_r   <= al_day_nxt;
      al_month_r <= al_month_nxt;
      al_year_r  <= al_year_nxt;
    end
  end

endmodule

[rtl/rtcal_out_reg.sv]
module rtcal_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  rtcal_pkg::out_item_t result,
  output logic                 fire,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rtcal_pkg::out_item_t out_data
);

  logic                 valid_r;
  rtcal_pkg::out_item_t data_r;
  logic                 free;

  // Take a new result when empty or when the current one leaves this cycle.
  assign free      = !valid_r || !out_stall;
  assign fire      = item_valid && free;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= result;
    end
  end

endmodule

[rtl/rtc_calendar_with_alarm.sv]
// Real-time clock and calendar with a one-shot alarm.
// Input channel (in_valid / in_stall / in_data) carries commands: one-second
// tick, set time, set date, set alarm. Every command yields exactly one result
// on the output channel (out_valid / out_stall / out_data) showing the clock
// after the command, the 12/24-hour display hour, the PM flag and an alarm hit.
// cfg_we / cfg_wdata write the 24-hour display mode; write it only when idle.
// Each input transaction passes the input register, then the update logic
// feeding the result register.
// Throughput: one transaction per cycle while out_stall is low; time and alarm
// state update per fire, so back-to-back commands see each other's effect.
// Reset (synchronous, rst_n low): 00:00:00, day 1, January, year 0, alarm
// disarmed, 24-hour mode; both pipeline registers empty.
// When out_stall is high the result holds; the input register still takes one
// more transaction and then asserts in_stall until the output drains.
module rtc_calendar_with_alarm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rtcal_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rtcal_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  logic                 item_valid;
  rtcal_pkg::in_item_t  item;
  rtcal_pkg::out_item_t result;
  logic                 fire;

  rtcal_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  rtcal_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  rtcal_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .fire       (fire),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[rtl/rtcal_checker.sv]
`include "assert_macros.svh"

module rtcal_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rtcal_pkg::out_item_t out_data
);

  // Input backpressure only ever comes from a stalled, full output.
  `ASSERT_IMPLY(a_in_stall_cause, in_stall, out_valid && out_stall)
  // An accepted transaction reaches the output unless out_stall holds it in the input register.
  `ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid)
  `ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_data_hold, out_valid && out_stall, $stable(out_data))

endmodule

bind rtc_calendar_with_alarm rtcal_checker u_rtcal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/rtc_calendar_with_alarm_tb.sv]
module rtc_calendar_with_alarm_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 220;
  localparam int PHASE_COUNT = 6;
  localparam int LONG_HOLD = 90;
  localparam int LONG_HOLD_AFTER = 64;
  localparam int MAX_REPORTS = 100;
  localparam logic [4:0] DAYS_PER_MONTH [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                                 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } clock_state_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  rtcal_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rtcal_pkg::out_item_t out_data;
  logic                 cfg_we = 1'b0;
  logic                 cfg_wdata = rtcal_pkg::MODE_24H_RESET;

  rtcal_pkg::in_item_t  pending_cmds[$];
  rtcal_pkg::out_item_t expected_display[$];
  clock_state_t         wall;
  clock_state_t         alarm_at;
  logic                 alarm_pending;
  logic                 show_24h;

  int err_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int queued_total = 0;
  int send_gap = 0;
  int send_burst = 0;
  int hold_left = 0;
  int free_left = 0;
  bit long_hold_done = 1'b0;

  rtc_calendar_with_alarm u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [4:0] days_in_month(logic [3:0] m);
    return (m < 4'd12) ? DAYS_PER_MONTH[m] : 5'd31;
  endfunction

  function automatic clock_state_t tick_once(clock_state_t c);
    clock_state_t n;
    n = c;
    if (c.second < rtcal_pkg::SEC_LAST) begin
      n.second = c.second + 6'd1;
    end else begin
      n.second = '0;
      if (c.minute < rtcal_pkg::MIN_LAST) begin
        n.minute = c.minute + 6'd1;
      end else begin
        n.minute = '0;
        if (c.hour < rtcal_pkg::HOUR_LAST) begin
          n.hour = c.hour + 5'd1;
        end else begin
          n.hour = '0;
          if (c.day >= days_in_month(c.month)) begin
            n.day = rtcal_pkg::DAY_FIRST;
            if (c.month >= rtcal_pkg::MONTH_LAST) begin
              n.month = '0;
              n.year = (c.year >= rtcal_pkg::YEAR_LAST) ? 14'd0 : c.year + 14'd1;
            end else begin
              n.month = c.month + 4'd1;
            end
          end else begin
            n.day = c.day + 5'd1;
          end
        end
      end
    end
    return n;
  endfunction

  function automatic clock_state_t clk_of(int h, int mi, int s, int d, int mo, int y);
    clock_state_t c;
    c.hour = 5'(h);
    c.minute = 6'(mi);
    c.second = 6'(s);
    c.day = 5'(d);
    c.month = 4'(mo);
    c.year = 14'(y);
    return c;
  endfunction

  // Apply one accepted command and record the display it must produce.
  function automatic void advance_clock_model(rtcal_pkg::in_item_t it);
    rtcal_pkg::out_item_t r;
    case (it.cmd)
      rtcal_pkg::CMD_TICK: wall = tick_once(wall);
      rtcal_pkg::CMD_SET_TIME: begin
        wall.hour = it.hour;
        wall.minute = it.minute;
        wall.second = it.second;
      end
      rtcal_pkg::CMD_SET_DATE: begin
        wall.day = it.day;
        wall.month = it.month;
        wall.year = it.year;
      end
      rtcal_pkg::CMD_SET_ALARM: begin
        alarm_at = {it.hour, it.minute, it.second, it.day, it.month, it.year};
        alarm_pending = 1'b1;
      end
    endcase
    r.alarm_hit = 1'b0;
    if (alarm_pending && wall == alarm_at) begin
      r.alarm_hit = 1'b1;
      alarm_pending = 1'b0;
    end
    r.shown_hour = show_24h ? wall.hour : wall.hour % rtcal_pkg::HOUR_HALF;
    r.cur_minute = wall.minute;
    r.cur_second = wall.second;
    r.cur_day = wall.day;
    r.cur_month = wall.month;
    r.cur_year = wall.year;
    r.is_pm = (wall.hour >= rtcal_pkg::HOUR_HALF);
    expected_display.push_back(r);
  endfunction

  // Unused fields carry random bits; the block must ignore them.
  function automatic void queue_command(rtcal_pkg::cmd_t c, clock_state_t s);
    logic [63:0] raw;
    rtcal_pkg::in_item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(rtcal_pkg::in_item_t)-1:0];
    it.cmd = c;
    if (c == rtcal_pkg::CMD_SET_TIME || c == rtcal_pkg::CMD_SET_ALARM) begin
      it.hour = s.hour;
      it.minute = s.minute;
      it.second = s.second;
    end
    if (c == rtcal_pkg::CMD_SET_DATE || c == rtcal_pkg::CMD_SET_ALARM) begin
      it.day = s.day;
      it.month = s.month;
      it.year = s.year;
    end
    pending_cmds.push_back(it);
    queued_total++;
  endfunction

  // Bias toward the last second, minute, hour, day, month and year.
  function automatic clock_state_t edge_clock();
    clock_state_t c;
    int r;
    c.hour = ($urandom_range(0, 2) == 0) ? rtcal_pkg::HOUR_LAST : 5'($urandom_range(0, 23));
    c.minute = ($urandom_range(0, 1) == 0) ? rtcal_pkg::MIN_LAST : 6'($urandom_range(0, 59));
    c.second = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(50, 59))
                                           : 6'($urandom_range(0, 59));
    c.month = ($urandom_range(0, 3) == 0) ? rtcal_pkg::MONTH_LAST
                                          : 4'($urandom_range(0, 11));
    r = $urandom_range(0, 9);
    if (r < 4) c.day = days_in_month(c.month);
    else if (r == 4) c.day = 5'($urandom_range(1, 31));
    else c.day = 5'($urandom_range(1, days_in_month(c.month)));
    r = $urandom_range(0, 9);
    if (r < 2) c.year = rtcal_pkg::YEAR_LAST;
    else if (r == 2) c.year = rtcal_pkg::YEAR_LAST - 14'd1;
    else c.year = 14'($urandom_range(0, 9999));
    return c;
  endfunction

  task automatic queue_random_part(int count);
    int first;
    int r;
    int k;
    logic [63:0] raw;
    clock_state_t s;
    clock_state_t target;
    first = queued_total;
    while (queued_total - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // Load a clock, arm the alarm k seconds ahead, then tick to it or past it.
        s = edge_clock();
        queue_command(rtcal_pkg::CMD_SET_TIME, s);
        queue_command(rtcal_pkg::CMD_SET_DATE, s);
        k = $urandom_range(0, 8);
        target = s;
        repeat (k) target = tick_once(target);
        if ($urandom_range(0, 6) == 0) target.year = target.year ^ 14'd1;
        queue_command(rtcal_pkg::CMD_SET_ALARM, target);
        repeat (k + $urandom_range(0, 3)) queue_command(rtcal_pkg::CMD_TICK, '0);
      end else if (r < 75) begin
        repeat ($urandom_range(1, 20)) queue_command(rtcal_pkg::CMD_TICK, '0);
      end else begin
        raw = {$urandom, $urandom};
        s = raw[$bits(clock_state_t)-1:0];
        queue_command(rtcal_pkg::cmd_t'($urandom_range(0, 3)), s);
      end
    end
  endtask

  task automatic wait_until_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_display.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    show_24h = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_send_gap();
    int r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_burst = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic pick_stall();
    int r;
    // Hold off once for a long stretch so the pipeline fills and stalls its input.
    if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      free_left = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      return 1'b1;
    end
    if (free_left > 0) begin
      free_left--;
      return 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) free_left = $urandom_range(1, 8);
    else if (r < 53) free_left = $urandom_range(50, 150);
    else if (r < 83) hold_left = $urandom_range(1, 3);
    else if (r < 98) hold_left = $urandom_range(4, 12);
    else hold_left = $urandom_range(30, 60);
    return 1'b0;
  endfunction

  function automatic void check_field(string name, logic [13:0] want, logic [13:0] got);
    if (got !== want) begin
      if (err_count < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_clock_model(in_data);
      // Hold the payload while stalled; otherwise idle or present the next command.
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_data <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_send_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    rtcal_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_display.size() == 0) begin
          if (err_count < MAX_REPORTS) $error("result transaction with nothing expected");
          err_count++;
        end else begin
          want = expected_display.pop_front();
          check_field("shown_hour", want.shown_hour, out_data.shown_hour);
          check_field("cur_minute", want.cur_minute, out_data.cur_minute);
          check_field("cur_second", want.cur_second, out_data.cur_second);
          check_field("cur_day", want.cur_day, out_data.cur_day);
          check_field("cur_month", want.cur_month, out_data.cur_month);
          check_field("cur_year", want.cur_year, out_data.cur_year);
          check_field("is_pm", want.is_pm, out_data.is_pm);
          check_field("alarm_hit", want.alarm_hit, out_data.alarm_hit);
        end
      end
      out_stall <= pick_stall();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("rtc_calendar_with_alarm regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    wall = clk_of(0, 0, 0, rtcal_pkg::DAY_FIRST, 0, 0);
    alarm_at = '0;
    alarm_pending = 1'b0;
    show_24h = rtcal_pkg::MODE_24H_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, in the reset display mode.
    queue_command(rtcal_pkg::CMD_TICK, '0);
    queue_command(rtcal_pkg::CMD_SET_TIME, clk_of(23, 59, 59, 0, 0, 0));
    queue_command(rtcal_pkg::CMD_SET_DATE, clk_of(0, 0, 0, 31, 11, 9999));
    queue_command(rtcal_pkg::CMD_SET_ALARM, clk_of(0, 0, 0, 1, 0, 0));
    queue_command(rtcal_pkg::CMD_TICK, '0);
    // Arm at the current time: fires on the arming command itself.
    queue_command(rtcal_pkg::CMD_SET_ALARM, clk_of(0, 0, 0, 1, 0, 0));
    // Out-of-range loads, day zero and a month index past December.
    queue_command(rtcal_pkg::CMD_SET_TIME, clk_of(31, 63, 63, 0, 0, 0));
    queue_command(rtcal_pkg::CMD_SET_DATE, clk_of(0, 0, 0, 0, 15, 16383));
    queue_command(rtcal_pkg::CMD_TICK, '0);
    queue_command(rtcal_pkg::CMD_SET_DATE, clk_of(0, 0, 0, 31, 15, 16383));
    queue_command(rtcal_pkg::CMD_SET_TIME, clk_of(23, 59, 59, 0, 0, 0));
    queue_command(rtcal_pkg::CMD_TICK, '0);
    // End of February and of a 30-day month.
    queue_command(rtcal_pkg::CMD_SET_DATE, clk_of(0, 0, 0, 28, 1, 2023));
    queue_command(rtcal_pkg::CMD_SET_TIME, clk_of(23, 59, 59, 0, 0, 0));
    queue_command(rtcal_pkg::CMD_TICK, '0);
    queue_command(rtcal_pkg::CMD_SET_DATE, clk_of(0, 0, 0, 30, 3, 100));
    queue_command(rtcal_pkg::CMD_SET_TIME, clk_of(23, 59, 59, 0, 0, 0));
    queue_command(rtcal_pkg::CMD_TICK, '0);
    queue_command(rtcal_pkg::CMD_SET_TIME, clk_of(12, 0, 0, 0, 0, 0));
    queue_command(rtcal_pkg::CMD_SET_ALARM, clk_of(12, 0, 2, 1, 4, 100));
    queue_command(rtcal_pkg::CMD_TICK, '0);
    queue_command(rtcal_pkg::CMD_TICK, '0);
    queue_command(rtcal_pkg::CMD_TICK, '0);
    queue_command(rtcal_pkg::CMD_SET_ALARM, clk_of(12, 0, 4, 1, 4, 101));
    queue_command(rtcal_pkg::CMD_TICK, '0);
    wait_until_drained();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      write_mode((phase % 2 == 0) ? 1'b0 : 1'b1);
      queue_random_part(PHASE_ITEMS);
      wait_until_drained();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("rtc_calendar_with_alarm regression: pass");
    end else begin
      $display("rtc_calendar_with_alarm regression: fail");
    end
    $finish;
  end

endmodule
